// ----- sv/krs_pkg.sv -----
// Shared types and constants for the key repeat scheduler.
// Used by krs_ctrl, krs_datapath and key_repeat_scheduler; depends on nothing.
package krs_pkg;

  // Defaults and fixed sizes
  localparam int unsigned QueueDepthDef = 8;
  localparam int unsigned NumCodes      = 8;

  // Register reset values
  localparam logic [15:0] RepeatWaitRst   = 16'd83;
  localparam logic [15:0] ConsInitWaitRst = 16'd500;
  localparam logic [15:0] ConsRepWaitRst  = 16'd83;
  localparam logic [63:0] ConsCodesRst    = 64'd0;
  localparam logic [15:0] KbNoneRst       = 16'hFFFF;
  localparam logic [7:0]  ConsNoneRst     = 8'hFF;
  localparam logic [15:0] MaxIdRst        = 16'd10000;

  // Operation codes of an input item
  typedef enum logic [2:0] {
    FUNC_TICK       = 3'd0,
    FUNC_KB_SET     = 3'd1,
    FUNC_CS_SET     = 3'd2,
    FUNC_ADD_KEY    = 3'd3,
    FUNC_ADD_DOWNUP = 3'd4,
    FUNC_ADD_CS     = 3'd5,
    FUNC_START      = 3'd6,
    FUNC_CANCEL     = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    EV_DOWN   = 2'd0,
    EV_UP     = 2'd1,
    EV_MODIFY = 2'd2,
    EV_OTHER  = 2'd3
  } ev_e;

  typedef enum logic [1:0] {
    KIND_KEY      = 2'd0,
    KIND_DOWNUP   = 2'd1,
    KIND_CONSUMER = 2'd2,
    KIND_ACK      = 2'd3
  } kind_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_REPEAT_WAIT    = 3'd0,
    CFG_CONS_INIT_WAIT = 3'd1,
    CFG_CONS_REP_WAIT  = 3'd2,
    CFG_CONS_CODES     = 3'd3,
    CFG_KB_NONE        = 3'd4,
    CFG_CONS_NONE      = 3'd5,
    CFG_MAX_ID         = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_EMIT
  } state_e;

  // One queued repeat entry (60 bits)
  typedef struct packed {
    kind_e       kind;
    ev_e         ev;
    logic [31:0] flags;
    logic [15:0] key;
    logic [7:0]  kbtype;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic take;     // capture input item
    logic exec;     // apply the item to the state
    logic idx_clr;  // restart the emit walk
    logic idx_inc;  // next entry
    logic load;     // move read entry into the output register
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic is_start;
    logic will_fire;
    logic out_free;
    logic idx_last;
  } ctl_sts_t;

endpackage

// ----- sv/krs_ctrl.sv -----
// Controller state machine of the key repeat scheduler.
// Depends on krs_pkg; drives commands into krs_datapath.
module krs_ctrl
  import krs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  ctl_sts_t sts_i,
  output ctl_cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          state_d    = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // a start needs the output register for its acknowledge
        if (!sts_i.is_start || sts_i.out_free) begin
          cmd_o.exec    = 1'b1;
          cmd_o.idx_clr = 1'b1;
          state_d       = sts_i.will_fire ? ST_READ : ST_IDLE;
        end
      end
      ST_READ: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load = 1'b1;
          if (sts_i.idx_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

// ----- sv/krs_datapath.sv -----
// Datapath of the key repeat scheduler: config registers, entry queue,
// countdown, repeat id and output register. Depends on krs_pkg.
module krs_datapath
  import krs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command and status
  input  ctl_cmd_t    cmd_i,
  output ctl_sts_t    sts_o,
  // input fields
  input  logic [2:0]  func_i,
  input  logic [1:0]  event_kind_i,
  input  logic [31:0] flags_i,
  input  logic [15:0] key_code_i,
  input  logic [7:0]  keyboard_type_i,
  input  logic [15:0] wait_ms_i,
  // output register
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [1:0]  out_event_kind_o,
  output logic [31:0] out_flags_o,
  output logic [15:0] out_key_code_o,
  output logic [7:0]  out_keyboard_type_o,
  output logic        is_repeat_o,
  output logic [15:0] repeat_id_o,
  output logic        last_o,
  // configuration
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IdxW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // Configuration registers
  logic [15:0] rep_wait_q, cons_init_q, cons_rep_q, kb_none_q, max_id_q;
  logic [63:0] cons_codes_q;
  logic [7:0]  cons_none_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_wait_q   <= RepeatWaitRst;
      cons_init_q  <= ConsInitWaitRst;
      cons_rep_q   <= ConsRepWaitRst;
      cons_codes_q <= ConsCodesRst;
      kb_none_q    <= KbNoneRst;
      cons_none_q  <= ConsNoneRst;
      max_id_q     <= MaxIdRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_REPEAT_WAIT:    rep_wait_q   <= cfg_wdata_i[15:0];
        CFG_CONS_INIT_WAIT: cons_init_q  <= cfg_wdata_i[15:0];
        CFG_CONS_REP_WAIT:  cons_rep_q   <= cfg_wdata_i[15:0];
        CFG_CONS_CODES:     cons_codes_q <= cfg_wdata_i;
        CFG_KB_NONE:        kb_none_q    <= cfg_wdata_i[15:0];
        CFG_CONS_NONE:      cons_none_q  <= cfg_wdata_i[7:0];
        CFG_MAX_ID:         max_id_q     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  // Captured input item
  func_e       func_q;
  ev_e         ev_q;
  logic [31:0] flags_q;
  logic [15:0] key_q;
  logic [7:0]  kbtype_q;
  logic [15:0] wait_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      func_q   <= func_e'(func_i);
      ev_q     <= ev_e'(event_kind_i);
      flags_q  <= flags_i;
      key_q    <= key_code_i;
      kbtype_q <= keyboard_type_i;
      wait_q   <= wait_ms_i;
    end
  end

  // Queue and timer state
  entry_t      mem_q [QUEUE_DEPTH];
  entry_t      rd_q;
  logic [CntW-1:0] count_q, count_d;
  logic [IdxW-1:0] idx_q;
  logic        has_cons_q, has_cons_d;
  kind_e       head_kind_q;
  logic [15:0] head_key_q;
  logic [15:0] cd_q, cd_d;
  logic        armed_q, armed_d;
  logic [15:0] id_q, id_next;
  logic [16:0] id_inc;

  // Key classification
  logic kb_none, cs_none, cs_rep, up_match;

  always_comb begin
    kb_none  = (key_q == kb_none_q);
    cs_none  = (key_q[15:8] == 8'd0) && (key_q[7:0] == cons_none_q);
    cs_rep   = 1'b0;
    for (int i = 0; i < NumCodes; i++) begin
      if (cons_codes_q[8*i +: 8] == key_q[7:0]) cs_rep = 1'b1;
    end
    cs_rep   = cs_rep && (key_q[15:8] == 8'd0);
    up_match = (count_q == CntW'(1)) && (head_kind_q != KIND_CONSUMER) &&
               (head_key_q == key_q);
  end

  // Id advance with wrap
  assign id_inc  = {1'b0, id_q} + 17'd1;
  assign id_next = (id_inc > {1'b0, max_id_q}) ? 16'd0 : id_inc[15:0];

  // Decode of the captured item into actions
  logic        do_clear, do_push, do_arm, do_fire, do_dec;
  kind_e       push_kind;
  ev_e         push_ev;
  logic [7:0]  push_kbtype;
  logic [15:0] arm_wait;

  always_comb begin
    do_clear    = 1'b0;
    do_push     = 1'b0;
    do_arm      = 1'b0;
    do_fire     = 1'b0;
    do_dec      = 1'b0;
    push_kind   = KIND_KEY;
    push_ev     = ev_q;
    push_kbtype = kbtype_q;
    arm_wait    = wait_q;
    unique case (func_q)
      FUNC_TICK: begin
        if (armed_q) begin
          if (cd_q <= 16'd1) do_fire = 1'b1;
          else do_dec = 1'b1;
        end
      end
      FUNC_KB_SET: begin
        if (!kb_none) begin
          if (ev_q == EV_DOWN) begin
            do_clear = 1'b1;
            do_push  = 1'b1;
            do_arm   = 1'b1;
          end else if (ev_q == EV_UP) begin
            do_clear = up_match;
          end else begin
            do_clear = 1'b1;
          end
        end
      end
      FUNC_CS_SET: begin
        if (!cs_none) begin
          do_clear = 1'b1;
          if (ev_q == EV_DOWN && cs_rep) begin
            do_push     = 1'b1;
            do_arm      = 1'b1;
            push_kind   = KIND_CONSUMER;
            push_kbtype = 8'd0;
            arm_wait    = cons_init_q;
          end
        end
      end
      FUNC_ADD_KEY: begin
        do_push = !kb_none;
      end
      FUNC_ADD_DOWNUP: begin
        do_push   = !kb_none;
        push_kind = KIND_DOWNUP;
        push_ev   = EV_DOWN;
      end
      FUNC_ADD_CS: begin
        do_push     = !cs_none;
        push_kind   = KIND_CONSUMER;
        push_kbtype = 8'd0;
      end
      FUNC_START: begin
        do_arm = 1'b1;
      end
      FUNC_CANCEL: begin
        do_clear = 1'b1;
      end
    endcase
  end

  // Queue bookkeeping
  logic [CntW-1:0] base_cnt;
  logic            push_ok;
  entry_t          push_entry;

  always_comb begin
    base_cnt   = do_clear ? '0 : count_q;
    push_ok    = do_push && (base_cnt < CntW'(QUEUE_DEPTH));
    push_entry = '{kind: push_kind, ev: push_ev, flags: flags_q,
                   key: key_q, kbtype: push_kbtype};
    count_d    = push_ok ? base_cnt + CntW'(1) : base_cnt;
    has_cons_d = (has_cons_q && !do_clear) ||
                 (push_ok && push_kind == KIND_CONSUMER);
  end

  // Timer update: arming wins over a clear in the same item
  always_comb begin
    cd_d    = cd_q;
    armed_d = armed_q;
    priority if (do_arm) begin
      cd_d    = arm_wait;
      armed_d = 1'b1;
    end else if (do_fire) begin
      cd_d    = has_cons_q ? cons_rep_q : rep_wait_q;
      armed_d = 1'b1;
    end else if (do_dec) begin
      cd_d = cd_q - 16'd1;
    end else if (do_clear) begin
      armed_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      has_cons_q <= 1'b0;
      cd_q       <= '0;
      armed_q    <= 1'b0;
      id_q       <= '0;
      idx_q      <= '0;
    end else begin
      if (cmd_i.exec) begin
        count_q    <= count_d;
        has_cons_q <= has_cons_d;
        cd_q       <= cd_d;
        armed_q    <= armed_d;
        if (do_arm) id_q <= id_next;
      end
      if (cmd_i.idx_clr) begin
        idx_q <= '0;
      end else if (cmd_i.idx_inc) begin
        idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push_ok) begin
      mem_q[base_cnt[IdxW-1:0]] <= push_entry;
    end
    rd_q <= mem_q[idx_q];
  end

  // Shadow of the head entry for the key-up match
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && push_ok && base_cnt == '0) begin
      head_kind_q <= push_kind;
      head_key_q  <= key_q;
    end
  end

  // Output register
  logic        out_valid_q;
  kind_e       out_kind_q;
  logic [1:0]  out_ev_q;
  logic [31:0] out_flags_q;
  logic [15:0] out_key_q, out_id_q;
  logic [7:0]  out_kbtype_q;
  logic        out_rep_q, out_last_q;
  logic        out_free, ack_load, idx_last;

  assign out_free = !out_valid_q || !out_stall_i;
  assign ack_load = cmd_i.exec && (func_q == FUNC_START);
  assign idx_last = ((CntW'(idx_q) + CntW'(1)) == count_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ack_load || cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ack_load) begin
      out_kind_q   <= KIND_ACK;
      out_ev_q     <= 2'd0;
      out_flags_q  <= '0;
      out_key_q    <= '0;
      out_kbtype_q <= '0;
      out_rep_q    <= 1'b0;
      out_id_q     <= id_next;
      out_last_q   <= 1'b1;
    end else if (cmd_i.load) begin
      out_kind_q   <= rd_q.kind;
      out_ev_q     <= rd_q.ev;
      out_flags_q  <= rd_q.flags;
      out_key_q    <= rd_q.key;
      out_kbtype_q <= rd_q.kbtype;
      out_rep_q    <= (rd_q.kind != KIND_DOWNUP) && (count_q == CntW'(1));
      out_id_q     <= id_q;
      out_last_q   <= idx_last;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_kind_o          = out_kind_q;
  assign out_event_kind_o    = out_ev_q;
  assign out_flags_o         = out_flags_q;
  assign out_key_code_o      = out_key_q;
  assign out_keyboard_type_o = out_kbtype_q;
  assign is_repeat_o         = out_rep_q;
  assign repeat_id_o         = out_id_q;
  assign last_o              = out_last_q;

  // Status to the controller
  always_comb begin
    sts_o.is_start  = (func_q == FUNC_START);
    sts_o.will_fire = (func_q == FUNC_TICK) && armed_q && (cd_q <= 16'd1) &&
                      (count_q != '0);
    sts_o.out_free  = out_free;
    sts_o.idx_last  = idx_last;
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QUEUE_DEPTH))
    else $error("entry count above queue depth");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load || ack_load) |-> out_free)
    else $error("output register overwritten while holding a result");

  a_ack_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ack_load |=> (out_valid_q && out_kind_q == KIND_ACK && out_last_q))
    else $error("start did not produce a final acknowledge");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.idx_inc |-> (CntW'(idx_q) + CntW'(1) < count_q))
    else $error("emit walk past the last entry");
`endif

endmodule

// ----- sv/key_repeat_scheduler.sv -----
// Key auto-repeat engine, top level.
// Input channel: in_valid_i/in_stall_o with func, event kind, flags, key
// code, keyboard type and wait; one item per millisecond tick or event.
// Output channel: out_valid_o/out_stall_i; last_o marks the final result
// of an item. Configuration: cfg_we_i writes cfg_wdata_i into register
// cfg_index_i; the user must write only while the block is idle, as the
// block itself does not enforce this. Timing: an item is taken in the
// idle state and applied in the exec state, where a start waits until
// the output register is free; its acknowledge is registered into the
// output register as it is applied. A firing tick walks the queue through
// the entry memory's single read port, a read and an emit state per entry.
// The last result of an item may still sit in the output register while
// the next item is accepted; the controller waits before overwriting it,
// so a stalled receiver holds the walk in place without losing results.
// Reset: configuration takes its defaults, the queue is empty, the timer
// is disarmed and the repeat id is zero. Queue entries have no reset.
// Depends on krs_pkg, krs_ctrl and krs_datapath.
module key_repeat_scheduler
  import krs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  func_i,
  input  logic [1:0]  event_kind_i,
  input  logic [31:0] flags_i,
  input  logic [15:0] key_code_i,
  input  logic [7:0]  keyboard_type_i,
  input  logic [15:0] wait_ms_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  out_kind_o,
  output logic [1:0]  out_event_kind_o,
  output logic [31:0] out_flags_o,
  output logic [15:0] out_key_code_o,
  output logic [7:0]  out_keyboard_type_o,
  output logic        is_repeat_o,
  output logic [15:0] repeat_id_o,
  output logic        last_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  krs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  krs_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .func_i              (func_i),
    .event_kind_i        (event_kind_i),
    .flags_i             (flags_i),
    .key_code_i          (key_code_i),
    .keyboard_type_i     (keyboard_type_i),
    .wait_ms_i           (wait_ms_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_kind_o          (out_kind_o),
    .out_event_kind_o    (out_event_kind_o),
    .out_flags_o         (out_flags_o),
    .out_key_code_o      (out_key_code_o),
    .out_keyboard_type_o (out_keyboard_type_o),
    .is_repeat_o         (is_repeat_o),
    .repeat_id_o         (repeat_id_o),
    .last_o              (last_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i)
  );

endmodule
